FILE: rtl/spei_pkg.sv
// ============================================================================
// spei_pkg
// Shared types, codes and constants of the spherical peak event integrator.
// ============================================================================
package spei_pkg;

    // Default sizes
    localparam int RUNS_DEF   = 256;
    localparam int DET_DEF    = 4096;
    localparam int FRAC_DEF   = 16;

    // Field widths
    localparam int SIG_W      = 32;
    localparam int RUN_IW     = 8;
    localparam int DET_IW     = 12;
    localparam int POS_W      = 24;
    localparam int MON_W      = 32;
    localparam int ACC_W      = 56;
    localparam int DIST_W     = 50;
    localparam int RAD_W      = 24;
    localparam int ST_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Index reduction: one conditional subtract per detector-index bit
    localparam int MOD_STEPS  = DET_IW;
    localparam int MOD_CW     = $clog2(MOD_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GCX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GCY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GCZ    = 3'd5;

    localparam logic [RAD_W-1:0] RADIUS_RST = 24'd4096;

    // Result status codes
    localparam logic [ST_W-1:0] ST_COUNTED = 3'd0;
    localparam logic [ST_W-1:0] ST_OUTSIDE = 3'd1;
    localparam logic [ST_W-1:0] ST_NONPOS  = 3'd2;
    localparam logic [ST_W-1:0] ST_MASKED  = 3'd3;
    localparam logic [ST_W-1:0] ST_NOMON   = 3'd4;
    localparam logic [ST_W-1:0] ST_ACK     = 3'd5;

    typedef enum logic [1:0] {
        ACT_EVENT = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_MASK  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MUL_DX  = 2'd0,
        MUL_DY  = 2'd1,
        MUL_DZ  = 2'd2,
        MUL_RAD = 2'd3
    } t_mul_sel;

    // Controller to datapath
    typedef struct packed {
        logic            load;
        logic            mod_step;
        logic            capture;
        logic            wr_entry;
        logic            wr_mask;
        logic            clr_wr;
        logic            mul_en;
        t_mul_sel        mul_sel;
        logic            dsq_clr;
        logic            dsq_add;
        logic            cmp_upd;
        logic            div_start;
        logic            div_step;
        logic            acc_upd;
        logic            st_set;
        logic [ST_W-1:0] st_val;
        logic            out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_action action;
        logic    nonpos;
        logic    masked;
        logic    no_mon;
        logic    in_sphere;
        logic    div_en;
        logic    div_last;
        logic    mod_last;
        logic    clr_last;
    } t_sts;

endpackage

FILE: rtl/spei_in_if.sv
// ============================================================================
// spei_in_if
// Input item channel: valid/ready handshake with the event or table payload.
// ============================================================================
interface spei_in_if;
    import spei_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic signed [SIG_W-1:0]  signal;
    logic [RUN_IW-1:0]        run;
    logic [DET_IW-1:0]        detector;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [MON_W-1:0]         monitor;
    logic                     mask_flag;

    modport source (
        output valid, action, signal, run, detector, pos_x, pos_y, pos_z, monitor, mask_flag,
        input  ready
    );
    modport sink (
        input  valid, action, signal, run, detector, pos_x, pos_y, pos_z, monitor, mask_flag,
        output ready
    );
endinterface

FILE: rtl/spei_out_if.sv
// ============================================================================
// spei_out_if
// Result channel: valid/ready handshake with status, run sum and distances.
// ============================================================================
interface spei_out_if;
    import spei_pkg::*;

    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [ACC_W-1:0]   run_sum;
    logic [DIST_W-1:0]  min_dist_sq;
    logic [DIST_W-1:0]  max_dist_sq;

    modport source (
        output valid, status, run_sum, min_dist_sq, max_dist_sq,
        input  ready
    );
    modport sink (
        input  valid, status, run_sum, min_dist_sq, max_dist_sq,
        output ready
    );
endinterface

FILE: rtl/spei_ram.sv
// ============================================================================
// spei_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module spei_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/spei_ctrl.sv
// ============================================================================
// spei_ctrl
// Sequencer: clearing pass, item intake, decision, distance, divide, result.
// ============================================================================
module spei_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  spei_pkg::t_sts i_sts,
    output spei_pkg::t_cmd o_cmd
);
    import spei_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_MOD   = 13'b0000000000100,
        S_READ  = 13'b0000000001000,
        S_EVAL  = 13'b0000000010000,
        S_SQX   = 13'b0000000100000,
        S_SQY   = 13'b0000001000000,
        S_SQZ   = 13'b0000010000000,
        S_SQR   = 13'b0000100000000,
        S_CMP   = 13'b0001000000000,
        S_DIV   = 13'b0010000000000,
        S_ADD   = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_oval, n_oval;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.capture = 1'b1;
                o_cmd.st_set  = 1'b1;
                o_cmd.st_val  = ST_ACK;
                n_state       = S_RESP;
                case (i_sts.action)
                    ACT_LOAD: o_cmd.wr_entry = 1'b1;
                    ACT_MASK: o_cmd.wr_mask  = 1'b1;
                    ACT_READ: o_cmd.st_set   = 1'b1;
                    ACT_EVENT: begin
                        if (i_sts.nonpos) begin
                            o_cmd.st_val = ST_NONPOS;
                        end else if (i_sts.masked) begin
                            o_cmd.st_val = ST_MASKED;
                        end else if (i_sts.no_mon) begin
                            o_cmd.st_val = ST_NOMON;
                        end else begin
                            o_cmd.st_set = 1'b0;
                            n_state      = S_SQX;
                        end
                    end
                    default: o_cmd.st_set = 1'b1;
                endcase
            end
            S_SQX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DX;
                o_cmd.dsq_clr = 1'b1;
                n_state       = S_SQY;
            end
            S_SQY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DY;
                o_cmd.dsq_add = 1'b1;
                n_state       = S_SQZ;
            end
            S_SQZ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DZ;
                o_cmd.dsq_add = 1'b1;
                n_state       = S_SQR;
            end
            S_SQR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_RAD;
                o_cmd.dsq_add = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_upd = 1'b1;
                if (!i_sts.in_sphere) begin
                    o_cmd.st_set = 1'b1;
                    o_cmd.st_val = ST_OUTSIDE;
                    n_state      = S_RESP;
                end else if (i_sts.div_en) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.acc_upd = 1'b1;
                o_cmd.st_set  = 1'b1;
                o_cmd.st_val  = ST_COUNTED;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (!r_oval || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Result valid flag: set on load, drop on transfer
    always_comb begin
        n_oval = r_oval;
        if (o_cmd.out_load) begin
            n_oval = 1'b1;
        end else if (i_out_ready) begin
            n_oval = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_oval;
endmodule

FILE: rtl/spei_dp.sv
// ============================================================================
// spei_dp
// Datapath: item and config registers, run and mask tables, distance
// multiplier, bit-serial divider, saturating accumulate and result register.
// ============================================================================
module spei_dp #(
    parameter int RUNS      = spei_pkg::RUNS_DEF,
    parameter int DETECTORS = spei_pkg::DET_DEF,
    parameter int FRAC_BITS = spei_pkg::FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spei_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spei_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                        i_action,
    input  logic signed [spei_pkg::SIG_W-1:0] i_signal,
    input  logic [spei_pkg::RUN_IW-1:0]       i_run,
    input  logic [spei_pkg::DET_IW-1:0]       i_detector,
    input  logic signed [spei_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [spei_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [spei_pkg::POS_W-1:0] i_pos_z,
    input  logic [spei_pkg::MON_W-1:0]        i_monitor,
    input  logic                              i_mask_flag,
    input  spei_pkg::t_cmd                    i_cmd,
    output spei_pkg::t_sts                    o_sts,
    output logic [spei_pkg::ST_W-1:0]         o_status,
    output logic [spei_pkg::ACC_W-1:0]        o_run_sum,
    output logic [spei_pkg::DIST_W-1:0]       o_min_dist_sq,
    output logic [spei_pkg::DIST_W-1:0]       o_max_dist_sq
);
    import spei_pkg::*;

    localparam int RUN_W = (RUNS > 1) ? $clog2(RUNS) : 1;
    localparam int DET_W = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
    localparam int CLR_N = (RUNS > DETECTORS) ? RUNS : DETECTORS;
    localparam int CLR_W = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam int DIVW  = SIG_W - 1 + FRAC_BITS;
    localparam int DCW   = $clog2(DIVW + 1);
    localparam int ENT_W = 3 * POS_W + MON_W;
    localparam int MUL_W = POS_W + 1;
    localparam int PRD_W = 2 * POS_W + 1;

    // Configuration registers
    logic [RAD_W-1:0]        r_radius;
    logic                    r_div;
    logic                    r_glob;
    logic signed [POS_W-1:0] r_gcx, r_gcy, r_gcz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_div    <= 1'b0;
            r_glob   <= 1'b1;
            r_gcx    <= '0;
            r_gcy    <= '0;
            r_gcz    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS: r_radius <= i_cfg_data;
                CFG_DIV:    r_div    <= i_cfg_data[0];
                CFG_GLOBAL: r_glob   <= i_cfg_data[0];
                CFG_GCX:    r_gcx    <= i_cfg_data;
                CFG_GCY:    r_gcy    <= i_cfg_data;
                CFG_GCZ:    r_gcz    <= i_cfg_data;
                default:    r_div    <= r_div;
            endcase
        end
    end

    // Item registers
    t_action                 r_action;
    logic signed [SIG_W-1:0] r_sig;
    logic [RUN_IW-1:0]       r_run;
    logic [DET_IW-1:0]       r_det;
    logic signed [POS_W-1:0] r_px, r_py, r_pz;
    logic [MON_W-1:0]        r_mon_in;
    logic                    r_flag;
    logic [MOD_CW-1:0]       r_mcnt;
    logic [31:0]             run_lim, det_lim;

    // Reduce run and detector by one shifted modulus per cycle
    assign run_lim = 32'(RUNS) << r_mcnt;
    assign det_lim = 32'(DETECTORS) << r_mcnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_sig    <= i_signal;
            r_run    <= i_run;
            r_det    <= i_detector;
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
            r_pz     <= i_pos_z;
            r_mon_in <= i_monitor;
            r_flag   <= i_mask_flag;
            r_mcnt   <= MOD_CW'(MOD_STEPS - 1);
        end else if (i_cmd.mod_step) begin
            if (32'(r_run) >= run_lim) begin
                r_run <= r_run - run_lim[RUN_IW-1:0];
            end
            if (32'(r_det) >= det_lim) begin
                r_det <= r_det - det_lim[DET_IW-1:0];
            end
            r_mcnt <= r_mcnt - 1'b1;
        end
    end

    // Table addresses
    logic [16:0]      run_ext;
    logic [20:0]      det_ext, clr_ext;
    logic [RUN_W-1:0] run_addr, clr_run;
    logic [DET_W-1:0] det_addr, clr_det;
    logic [CLR_W-1:0] r_ccnt;
    logic             clr_run_ok, clr_det_ok;

    assign run_ext    = 17'(r_run);
    assign det_ext    = 21'(r_det);
    assign clr_ext    = 21'(r_ccnt);
    assign run_addr   = run_ext[RUN_W-1:0];
    assign det_addr   = det_ext[DET_W-1:0];
    assign clr_run    = clr_ext[RUN_W-1:0];
    assign clr_det    = clr_ext[DET_W-1:0];
    assign clr_run_ok = (32'(r_ccnt) < 32'(RUNS));
    assign clr_det_ok = (32'(r_ccnt) < 32'(DETECTORS));

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt <= '0;
        end else if (i_cmd.clr_wr && !o_sts.clr_last) begin
            r_ccnt <= r_ccnt + 1'b1;
        end
    end

    // Run entry table: centre x, y, z and monitor
    logic [ENT_W-1:0] ent_q;
    logic [ACC_W-1:0] acc_q, n_acc;
    logic             mask_q;

    spei_ram #(.WIDTH(ENT_W), .DEPTH(RUNS)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    ((i_cmd.clr_wr && clr_run_ok) || i_cmd.wr_entry),
        .i_waddr (i_cmd.clr_wr ? clr_run : run_addr),
        .i_wdata (i_cmd.clr_wr ? '0 : {r_px, r_py, r_pz, r_mon_in}),
        .i_raddr (run_addr),
        .o_rdata (ent_q)
    );

    spei_ram #(.WIDTH(ACC_W), .DEPTH(RUNS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    ((i_cmd.clr_wr && clr_run_ok) || i_cmd.acc_upd),
        .i_waddr (i_cmd.clr_wr ? clr_run : run_addr),
        .i_wdata (i_cmd.clr_wr ? '0 : n_acc),
        .i_raddr (run_addr),
        .o_rdata (acc_q)
    );

    spei_ram #(.WIDTH(1), .DEPTH(DETECTORS)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    ((i_cmd.clr_wr && clr_det_ok) || i_cmd.wr_mask),
        .i_waddr (i_cmd.clr_wr ? clr_det : det_addr),
        .i_wdata (i_cmd.clr_wr ? 1'b0 : r_flag),
        .i_raddr (det_addr),
        .o_rdata (mask_q)
    );

    // Capture the centre in use, the monitor and the accumulator
    logic signed [POS_W-1:0] r_cx, r_cy, r_cz;
    logic [MON_W-1:0]        r_mon;
    logic [ACC_W-1:0]        r_acc;
    logic [MON_W-1:0]        ent_mon;

    assign ent_mon = ent_q[MON_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cx  <= r_glob ? r_gcx : ent_q[ENT_W-1 -: POS_W];
            r_cy  <= r_glob ? r_gcy : ent_q[ENT_W-POS_W-1 -: POS_W];
            r_cz  <= r_glob ? r_gcz : ent_q[MON_W+POS_W-1 -: POS_W];
            r_mon <= ent_mon;
            r_acc <= acc_q;
        end else if (i_cmd.acc_upd) begin
            r_acc <= n_acc;
        end
    end

    // Shared squarer: one square per cycle into the product register
    logic signed [MUL_W-1:0] m_op;
    logic signed [2*MUL_W-1:0] m_prod;
    logic [PRD_W-1:0]        r_prod;
    logic [DIST_W-1:0]       r_dsq;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DX:  m_op = MUL_W'(r_px) - MUL_W'(r_cx);
            MUL_DY:  m_op = MUL_W'(r_py) - MUL_W'(r_cy);
            MUL_DZ:  m_op = MUL_W'(r_pz) - MUL_W'(r_cz);
            MUL_RAD: m_op = $signed({1'b0, r_radius});
            default: m_op = '0;
        endcase
    end

    assign m_prod = m_op * m_op;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= m_prod[PRD_W-1:0];
        end
        if (i_cmd.dsq_clr) begin
            r_dsq <= '0;
        end else if (i_cmd.dsq_add) begin
            r_dsq <= r_dsq + DIST_W'(r_prod);
        end
    end

    // Running minimum and maximum of the squared distance
    logic [DIST_W-1:0] r_min, r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
        end else if (i_cmd.cmp_upd) begin
            if (r_dsq < r_min) begin
                r_min <= r_dsq;
            end
            if (r_dsq > r_max) begin
                r_max <= r_dsq;
            end
        end
    end

    // Bit-serial restoring divider: one quotient bit per cycle
    logic [DIVW-1:0]  r_quo;
    logic [MON_W:0]   r_rem, rem_sh;
    logic [DCW-1:0]   r_dcnt;
    logic             q_bit;

    assign rem_sh = {r_rem[MON_W-1:0], r_quo[DIVW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_mon});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo  <= DIVW'(r_sig[SIG_W-2:0]) << FRAC_BITS;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? (rem_sh - {1'b0, r_mon}) : rem_sh;
            r_quo  <= {r_quo[DIVW-2:0], q_bit};
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Saturating accumulate
    logic [ACC_W-1:0] addend;
    logic [ACC_W:0]   acc_sum;

    assign addend  = r_div ? ACC_W'(r_quo) : (ACC_W'(r_sig[SIG_W-2:0]) << FRAC_BITS);
    assign acc_sum = {1'b0, r_acc} + {1'b0, addend};
    assign n_acc   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

    // Status and result registers
    logic [ST_W-1:0]   r_status;
    logic [ST_W-1:0]   r_o_status;
    logic [ACC_W-1:0]  r_o_sum;
    logic [DIST_W-1:0] r_o_min, r_o_max;

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_set) begin
            r_status <= i_cmd.st_val;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_sum    <= r_acc;
            r_o_min    <= r_min;
            r_o_max    <= r_max;
        end
    end

    assign o_status      = r_o_status;
    assign o_run_sum     = r_o_sum;
    assign o_min_dist_sq = r_o_min;
    assign o_max_dist_sq = r_o_max;

    // Status to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.action    = r_action;
        o_sts.nonpos    = (r_sig == '0) || r_sig[SIG_W-1];
        o_sts.masked    = mask_q;
        o_sts.no_mon    = r_div && (ent_mon == '0);
        o_sts.in_sphere = (r_dsq < DIST_W'(r_prod));
        o_sts.div_en    = r_div;
        o_sts.div_last  = (r_dcnt == DCW'(DIVW - 1));
        o_sts.mod_last  = (r_mcnt == '0);
        o_sts.clr_last  = (r_ccnt == CLR_W'(CLR_N - 1));
    end

    // Checks
    a_minmax_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max != '0) |-> (r_min <= r_max))
        else $error("minimum distance above maximum");

    a_acc_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_upd |=> (r_acc >= $past(r_acc)))
        else $error("accumulator decreased");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_rem < {1'b0, r_mon}))
        else $error("divider remainder not below divisor");
endmodule

FILE: rtl/sphere_peak_event_integrator_unit.sv
// ============================================================================
// sphere_peak_event_integrator_unit
// Spherical peak integration over a stream of detector events, with per-run
// centre, monitor and accumulator tables and a detector mask table.
// ============================================================================
//  channel   direction  handshake      payload
//  i_item    in         valid/ready    action, signal, run, detector, pos, monitor, mask
//  o_res     out        valid/ready    status, run_sum, min/max_dist_sq
//  i_cfg_*   in         write enable   register index, data (24 bit)
//
//  One item at a time: intake, index reduction, then table read and decision.
//  Table items and skipped events then load the result. Events first do the
//  distance work on the shared squarer (an event outside the sphere goes
//  straight to its result), then divide when dividing, accumulate and load.
//  After reset a clearing pass over max(RUNS, DETECTORS) addresses zeroes the
//  tables; no item is taken during it. A stalled result holds the block in its
//  result step before the next result is loaded; a new item is still taken
//  while the previous result waits.
// ============================================================================
module sphere_peak_event_integrator_unit #(
    parameter int RUNS      = spei_pkg::RUNS_DEF,
    parameter int DETECTORS = spei_pkg::DET_DEF,
    parameter int FRAC_BITS = spei_pkg::FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spei_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spei_pkg::CFG_DATA_W-1:0] i_cfg_data,
    spei_in_if.sink                         i_item,
    spei_out_if.source                      o_res
);
    import spei_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    spei_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath
    spei_dp #(
        .RUNS      (RUNS),
        .DETECTORS (DETECTORS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_item.action),
        .i_signal      (i_item.signal),
        .i_run         (i_item.run),
        .i_detector    (i_item.detector),
        .i_pos_x       (i_item.pos_x),
        .i_pos_y       (i_item.pos_y),
        .i_pos_z       (i_item.pos_z),
        .i_monitor     (i_item.monitor),
        .i_mask_flag   (i_item.mask_flag),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_res.status),
        .o_run_sum     (o_res.run_sum),
        .o_min_dist_sq (o_res.min_dist_sq),
        .o_max_dist_sq (o_res.max_dist_sq)
    );
endmodule
